@@ design/lts_pkg.sv @@
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types and constants of the line token splitter: token kinds, scan
// modes, configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int MAX_LINE_LEN_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [BYTE_W-1:0] STAR_CHAR  = 8'd42;
  localparam logic [BYTE_W-1:0] QUOTE_CHAR = 8'd34;
  localparam logic [BYTE_W-1:0] EOL_CHAR   = 8'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_SEP_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CMT_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CMT_B = 3'd5;

  localparam logic [BYTE_W-1:0] SEP_A_RST = 8'd32;
  localparam logic [BYTE_W-1:0] SEP_B_RST = 8'd9;
  localparam logic [BYTE_W-1:0] SEP_C_RST = 8'd0;
  localparam logic [BYTE_W-1:0] SEP_D_RST = 8'd0;
  localparam logic [BYTE_W-1:0] CMT_A_RST = 8'd37;
  localparam logic [BYTE_W-1:0] CMT_B_RST = 8'd0;

  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_STAR = 2'd1,
    KIND_CMT  = 2'd2,
    KIND_EOL  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_COMMENT = 2'd2
  } mode_t;

  // which results one input byte produces, in output order word, mid, eol
  typedef struct packed {
    logic has_word;
    logic has_mid;
    logic mid_is_cmt;
    logic has_eol;
    logic ovf;
  } tok_flags_t;

endpackage

@@ design/lts_front.sv @@
// ----------------------------------------------------------------------------
// lts_front
// Accepts line bytes, classifies them against the separator and comment
// registers, tracks the scan state and pushes one bundle of results per
// byte that produces any.
// ----------------------------------------------------------------------------
module lts_front #(
  parameter int MAX_LINE_LEN = lts_pkg::MAX_LINE_LEN_DEF,
  parameter int POS_W        = $clog2(MAX_LINE_LEN + 1),
  parameter int DATA_W       = $bits(lts_pkg::tok_flags_t) + 5 * POS_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lts_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lts_pkg::BYTE_W-1:0]    in_ch,
  input  logic                          q_full,
  output logic                          push,
  output logic [DATA_W-1:0]             push_data
);

  localparam logic [POS_W-1:0] LIM = POS_W'(MAX_LINE_LEN);

  logic [lts_pkg::BYTE_W-1:0] sep_a_r, sep_b_r, sep_c_r, sep_d_r, cmt_a_r, cmt_b_r;

  lts_pkg::mode_t   mode_r, mode_nxt;
  logic             quote_r, quote_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] tok_r, tok_nxt;
  logic             ovf_r, ovf_nxt;

  logic                accept;
  logic                is_sep, is_cmt;
  lts_pkg::tok_flags_t flags;
  logic [POS_W-1:0]    word_start, word_len, mid_start, mid_len, eol_len;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign is_sep = (sep_a_r != '0 && in_ch == sep_a_r) || (sep_b_r != '0 && in_ch == sep_b_r) ||
                  (sep_c_r != '0 && in_ch == sep_c_r) || (sep_d_r != '0 && in_ch == sep_d_r);
  assign is_cmt = (cmt_a_r != '0 && in_ch == cmt_a_r) || (cmt_b_r != '0 && in_ch == cmt_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_a_r <= lts_pkg::SEP_A_RST;
      sep_b_r <= lts_pkg::SEP_B_RST;
      sep_c_r <= lts_pkg::SEP_C_RST;
      sep_d_r <= lts_pkg::SEP_D_RST;
      cmt_a_r <= lts_pkg::CMT_A_RST;
      cmt_b_r <= lts_pkg::CMT_B_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lts_pkg::CFG_SEP_A: sep_a_r <= cfg_wdata;
        lts_pkg::CFG_SEP_B: sep_b_r <= cfg_wdata;
        lts_pkg::CFG_SEP_C: sep_c_r <= cfg_wdata;
        lts_pkg::CFG_SEP_D: sep_d_r <= cfg_wdata;
        lts_pkg::CFG_CMT_A: cmt_a_r <= cfg_wdata;
        lts_pkg::CFG_CMT_B: cmt_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lts_pkg::MODE_BETWEEN;
      quote_r <= 1'b0;
      pos_r   <= '0;
      tok_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      pos_r   <= pos_nxt;
      tok_r   <= tok_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    logic [POS_W-1:0] off;
    logic             at_lim;
    off        = pos_r;
    at_lim     = (pos_r >= LIM);
    mode_nxt   = mode_r;
    quote_nxt  = quote_r;
    tok_nxt    = tok_r;
    ovf_nxt    = ovf_r;
    pos_nxt    = pos_r;
    flags      = '0;
    word_start = tok_r;
    word_len   = '0;
    mid_start  = '0;
    mid_len    = '0;
    eol_len    = pos_r;

    if (in_ch == lts_pkg::EOL_CHAR) begin
      flags.ovf     = ovf_r;
      flags.has_eol = 1'b1;
      word_len      = (pos_r >= tok_r) ? pos_r - tok_r : '0;
      if (mode_r == lts_pkg::MODE_WORD && !quote_r) begin
        flags.has_word = 1'b1;
      end else if (mode_r == lts_pkg::MODE_COMMENT) begin
        // comment token is carried in the mid slot
        flags.has_mid    = 1'b1;
        flags.mid_is_cmt = 1'b1;
        mid_start        = tok_r;
        mid_len          = word_len;
      end
      mode_nxt  = lts_pkg::MODE_BETWEEN;
      quote_nxt = 1'b0;
      pos_nxt   = '0;
      tok_nxt   = '0;
      ovf_nxt   = 1'b0;
    end else begin
      if (at_lim) begin
        off     = LIM;
        ovf_nxt = 1'b1;
      end
      if (mode_r != lts_pkg::MODE_COMMENT) begin
        if (mode_r == lts_pkg::MODE_BETWEEN && !is_sep) begin
          mode_nxt = lts_pkg::MODE_WORD;
          tok_nxt  = off;
        end
        if (mode_nxt == lts_pkg::MODE_WORD) begin
          if (in_ch == lts_pkg::QUOTE_CHAR) begin
            quote_nxt = !quote_r;
          end
          if (!quote_nxt && is_sep) begin
            flags.has_word = 1'b1;
            word_start     = tok_nxt;
            word_len       = (off >= tok_nxt) ? off - tok_nxt : '0;
            mode_nxt       = lts_pkg::MODE_BETWEEN;
          end
          if (in_ch == lts_pkg::STAR_CHAR) begin
            flags.has_mid = 1'b1;
            mid_start     = off;
            mid_len       = POS_W'(1);
            tok_nxt       = (off >= LIM) ? LIM : off + POS_W'(1);
          end
        end
        if (is_cmt) begin
          mode_nxt  = lts_pkg::MODE_COMMENT;
          quote_nxt = 1'b0;
          tok_nxt   = off;
        end
      end
      pos_nxt   = (off >= LIM) ? LIM : off + POS_W'(1);
      flags.ovf = ovf_nxt;
    end
  end

  assign push      = accept && (flags.has_word || flags.has_mid || flags.has_eol);
  assign push_data = {flags, word_start, word_len, mid_start, mid_len, eol_len};

  a_between_unquoted: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == lts_pkg::MODE_BETWEEN |-> !quote_r)
    else $error("quote flag set between tokens");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LIM && tok_r <= LIM)
    else $error("position beyond line limit");

endmodule

@@ design/lts_queue.sv @@
// ----------------------------------------------------------------------------
// lts_queue
// Small flop queue of result bundles between the classifier and the
// result sequencer.
// ----------------------------------------------------------------------------
module lts_queue #(
  parameter int DEPTH  = lts_pkg::QUEUE_DEPTH_DEF,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output logic [DATA_W-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ design/lts_back.sv @@
// ----------------------------------------------------------------------------
// lts_back
// Walks the head bundle of the queue and sends its results one beat at a
// time through the output register, marking the last one of each byte.
// ----------------------------------------------------------------------------
module lts_back #(
  parameter int POS_W  = 11,
  parameter int DATA_W = $bits(lts_pkg::tok_flags_t) + 5 * POS_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  logic [DATA_W-1:0] q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [POS_W-1:0]  out_start_res,
  output logic [POS_W-1:0]  out_length,
  output logic              out_overflow,
  output logic              out_last
);

  lts_pkg::tok_flags_t hd_flags;
  logic [POS_W-1:0]    hd_word_start, hd_word_len, hd_mid_start, hd_mid_len, hd_eol_len;

  logic [2:0]       done_r, done_nxt;
  logic [2:0]       pending, sel, rest;
  logic             load;
  logic             valid_r, valid_nxt;
  lts_pkg::kind_t   kind_r, kind_nxt;
  logic [POS_W-1:0] start_r, start_nxt, len_r, len_nxt;
  logic             ovf_r, last_r, last_nxt;

  assign {hd_flags, hd_word_start, hd_word_len, hd_mid_start, hd_mid_len, hd_eol_len} = q_rdata;

  assign load    = !valid_r || out_ready;
  assign pending = {hd_flags.has_eol, hd_flags.has_mid, hd_flags.has_word} & ~done_r;
  assign sel     = pending & (~pending + 3'd1);
  assign rest    = pending & ~sel;

  always_comb begin
    kind_nxt  = lts_pkg::KIND_EOL;
    start_nxt = '0;
    len_nxt   = hd_eol_len;
    if (sel[0]) begin
      kind_nxt  = lts_pkg::KIND_WORD;
      start_nxt = hd_word_start;
      len_nxt   = hd_word_len;
    end else if (sel[1]) begin
      kind_nxt  = hd_flags.mid_is_cmt ? lts_pkg::KIND_CMT : lts_pkg::KIND_STAR;
      start_nxt = hd_mid_start;
      len_nxt   = hd_mid_len;
    end
    last_nxt  = (rest == 3'b000);
    valid_nxt = load ? q_not_empty : valid_r;
    q_pop     = load && q_not_empty && last_nxt;
    done_nxt  = done_r;
    if (load && q_not_empty) begin
      done_nxt = last_nxt ? 3'b000 : (done_r | sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= 3'b000;
    end else begin
      valid_r <= valid_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_not_empty) begin
      kind_r  <= kind_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      ovf_r   <= hd_flags.ovf;
      last_r  <= last_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_kind      = kind_r;
  assign out_start_res = start_r;
  assign out_length    = len_r;
  assign out_overflow  = ovf_r;
  assign out_last      = last_r;

  a_eol_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == lts_pkg::KIND_EOL |-> last_r)
    else $error("end of line marker not last beat");

  a_star_len: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == lts_pkg::KIND_STAR |-> len_r == POS_W'(1) && last_r)
    else $error("asterisk token malformed");

endmodule

@@ design/line_token_splitter_core.sv @@
// ----------------------------------------------------------------------------
// line_token_splitter_core
// Path: an accepted byte's results are written into the queue on the
// accepting edge, then loaded into the output register. Throughput: one
// byte per cycle while the queue is not full; a byte giving k results holds
// the output for k beats; a 4-bundle queue absorbs multi-result bursts.
// Reset: synchronous active-low; scan state, queue and output clear, the
// separator and comment registers return to their defaults.
// ----------------------------------------------------------------------------
module line_token_splitter_core #(
  parameter int MAX_LINE_LEN = lts_pkg::MAX_LINE_LEN_DEF,
  parameter int QUEUE_DEPTH  = lts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [lts_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lts_pkg::BYTE_W-1:0]            cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [lts_pkg::BYTE_W-1:0]            in_ch,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_kind,
  output logic [$clog2(MAX_LINE_LEN + 1)-1:0]   out_start_res,
  output logic [$clog2(MAX_LINE_LEN + 1)-1:0]   out_length,
  output logic                                  out_overflow,
  output logic                                  out_last
);

  localparam int POS_W  = $clog2(MAX_LINE_LEN + 1);
  localparam int DATA_W = $bits(lts_pkg::tok_flags_t) + 5 * POS_W;

  logic              push, pop, q_full, q_not_empty;
  logic [DATA_W-1:0] push_data, q_rdata;

  lts_front #(
    .MAX_LINE_LEN (MAX_LINE_LEN),
    .POS_W        (POS_W),
    .DATA_W       (DATA_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  lts_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  lts_back #(
    .POS_W  (POS_W),
    .DATA_W (DATA_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_rdata       (q_rdata),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_start_res (out_start_res),
    .out_length    (out_length),
    .out_overflow  (out_overflow),
    .out_last      (out_last)
  );

endmodule
